>>> hw/rtl/tcds_pkg.sv
// Package for threshold_count_done_set: shared types and constants.
// No dependencies; used by the interfaces, the cell and the top level.
package tcds_pkg;

    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    // func codes
    localparam logic FUNC_QUERY  = 1'b0;
    localparam logic FUNC_RECORD = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DONE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_PRIMES   = 1'd1;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    // token walking down the cell chain
    typedef struct packed {
        logic               act;      // token present in this slot
        logic               rec;      // record item
        logic               kind_ok;  // result kind matches configured kind
        logic               found;    // value hit or allocated upstream
        logic               done;     // value done after this item
        logic               became;   // this record reached the threshold
        logic [COUNT_W-1:0] thr;      // effective threshold
        logic [VALUE_W-1:0] value;
    } token_t;

endpackage

>>> hw/rtl/tcds_if.sv
// Channel interfaces for threshold_count_done_set: input, result, config write.
// Depends on tcds_pkg for field widths.
interface tcds_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [tcds_pkg::VALUE_W-1:0]  value;
    logic                          is_prime;
    modport source (output valid, func, value, is_prime, input ready);
    modport sink   (input valid, func, value, is_prime, output ready);
endinterface

interface tcds_out_if;
    logic       valid;
    logic       ready;
    logic       is_new;
    logic       became_done;
    logic [1:0] status;
    modport source (output valid, is_new, became_done, status, input ready);
    modport sink   (input valid, is_new, became_done, status, output ready);
endinterface

interface tcds_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tcds_pkg::CFG_IDX_W-1:0]  index;
    logic [tcds_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/tcds_cell.sv
// One table entry of threshold_count_done_set: value, hit count, valid bit.
// Looks at the passing token, updates itself, hands the token on. Uses tcds_pkg.
module tcds_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  tcds_pkg::token_t tok_in,
    output tcds_pkg::token_t tok_out
);

    logic                           valid_reg, valid_next;
    logic [tcds_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic [tcds_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [tcds_pkg::COUNT_W-1:0]   count_inc;
    tcds_pkg::token_t               tok_reg, tok_next;
    logic                           hit;
    logic                           alloc;

    always_comb
    begin
        hit   = tok_in.act && valid_reg && (value_reg == tok_in.value);
        // table fills from the front, so the first free cell is the free one
        alloc = tok_in.act && !valid_reg && !tok_in.found && tok_in.rec && tok_in.kind_ok;
        count_inc  = count_reg + 1'b1;
        valid_next = valid_reg;
        value_next = value_reg;
        count_next = count_reg;
        tok_next   = tok_in;
        if (hit)
        begin
            tok_next.found = 1'b1;
            if (tok_in.rec && tok_in.kind_ok && (count_reg < tok_in.thr))
            begin
                count_next      = count_inc;
                tok_next.became = (count_inc == tok_in.thr);
                tok_next.done   = (count_inc >= tok_in.thr);
            end
            else
            begin
                tok_next.done = (count_reg >= tok_in.thr);
            end
        end
        else if (alloc)
        begin
            valid_next      = 1'b1;
            value_next      = tok_in.value;
            count_next      = {{(tcds_pkg::COUNT_W-1){1'b0}}, 1'b1};
            tok_next.found  = 1'b1;
            tok_next.became = (tok_in.thr == {{(tcds_pkg::COUNT_W-1){1'b0}}, 1'b1});
            tok_next.done   = tok_next.became;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        count_reg <= count_next;
    end

    assign tok_out = tok_reg;

endmodule

>>> hw/rtl/threshold_count_done_set.sv
// Top level of threshold_count_done_set: config registers, token injection,
// chain of tcds_cell entries, result skid and output register. Uses tcds_pkg, tcds_if.
//
//  channel  | dir | fields                         | handshake
//  in_ch    | in  | func, value, is_prime          | valid/ready
//  out_ch   | out | is_new, became_done, status    | valid/ready
//  cfg_ch   | in  | index, data                    | valid/ready, ready always high
//
// An item walks the cell chain one entry per cycle, then the skid and the output register;
// one item is in the chain at a time, so the chain length sets the rate: the next word
// is taken once the previous result moves from the skid register to the output register.
// Reset clears all entry valid bits at once; no clearing pass.
// A result waiting on out_ch does not block accepting the next item; a second
// finished result waits in a skid register, and in_ch.ready stays low until it moves on.
module threshold_count_done_set #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    tcds_in_if.sink      in_ch,
    tcds_out_if.source   out_ch,
    tcds_cfg_if.sink     cfg_ch
);

    logic [tcds_pkg::COUNT_W-1:0] thr_reg;
    logic                         primes_reg;
    logic [tcds_pkg::COUNT_W-1:0] thr_eff;

    tcds_pkg::token_t inject_reg, inject_next;
    tcds_pkg::token_t tok_chain [TABLE_ENTRIES+1];
    tcds_pkg::token_t tok_exit;

    logic       busy_reg, busy_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       pend_new_reg, pend_new_next;
    logic       pend_became_reg, pend_became_next;
    logic [1:0] pend_status_reg, pend_status_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_new_reg, out_new_next;
    logic       out_became_reg, out_became_next;
    logic [1:0] out_status_reg, out_status_next;
    logic       in_fire;
    logic       move;

    // configuration
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= {{(tcds_pkg::COUNT_W-1){1'b0}}, 1'b1};
            primes_reg <= 1'b1;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                tcds_pkg::REG_DONE_THRESHOLD: thr_reg    <= cfg_ch.data;
                tcds_pkg::REG_COUNT_PRIMES:   primes_reg <= cfg_ch.data[0];
                default: ;
            endcase
        end
    end

    // a zero threshold acts as one
    assign thr_eff = (thr_reg == '0) ? {{(tcds_pkg::COUNT_W-1){1'b0}}, 1'b1} : thr_reg;

    assign in_ch.ready = !busy_reg;
    assign in_fire     = in_ch.valid && !busy_reg;

    always_comb
    begin
        inject_next         = '0;
        inject_next.act     = in_fire;
        inject_next.rec     = (in_ch.func == tcds_pkg::FUNC_RECORD);
        inject_next.kind_ok = (in_ch.is_prime == primes_reg);
        inject_next.thr     = thr_eff;
        inject_next.value   = in_ch.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inject_reg <= '0;
        else
            inject_reg <= inject_next;
    end

    assign tok_chain[0] = inject_reg;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        tcds_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1])
        );
    end

    assign tok_exit = tok_chain[TABLE_ENTRIES];

    // result staging
    assign move = pend_valid_reg && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_new_next    = pend_new_reg;
        pend_became_next = pend_became_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;
        out_new_next     = out_new_reg;
        out_became_next  = out_became_reg;
        out_status_next  = out_status_reg;
        busy_next        = busy_reg;

        if (in_fire)
            busy_next = 1'b1;

        if (out_ch.ready)
            out_valid_next = 1'b0;
        if (move)
        begin
            out_valid_next  = 1'b1;
            out_new_next    = pend_new_reg;
            out_became_next = pend_became_reg;
            out_status_next = pend_status_reg;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end

        if (tok_exit.act)
        begin
            pend_valid_next  = 1'b1;
            pend_new_next    = !tok_exit.done;
            pend_became_next = tok_exit.became;
            if (tok_exit.rec && !tok_exit.kind_ok)
                pend_status_next = tcds_pkg::STATUS_MISMATCH;
            else if (tok_exit.rec && !tok_exit.found)
                pend_status_next = tcds_pkg::STATUS_FULL;
            else
                pend_status_next = tcds_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_new_reg    <= pend_new_next;
        pend_became_reg <= pend_became_next;
        pend_status_reg <= pend_status_next;
        out_new_reg     <= out_new_next;
        out_became_reg  <= out_became_next;
        out_status_reg  <= out_status_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.is_new      = out_new_reg;
    assign out_ch.became_done = out_became_reg;
    assign out_ch.status      = out_status_reg;

endmodule
